/* rtl/tpq_pkg.sv */
`timescale 1ns / 1ps

package tpq_pkg;

   // queue geometry
   localparam int DEPTH   = 8;
   localparam int ID_BITS = 16;
   localparam int LEVELS  = 3;

   // derived widths
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ADDR_W  = $clog2(LEVELS * DEPTH);
   localparam int SUM_W   = CNT_W + 2;

   // fixed port widths
   localparam int TASK_W  = 16;
   localparam int PRIO_W  = 2;
   localparam int LVL_W   = 2;
   localparam int TOTAL_W = 5;

   // operation codes
   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   // priority request codes (anything else is the high level)
   localparam logic [PRIO_W-1:0] PRIO_LOW = 2'd1;
   localparam logic [PRIO_W-1:0] PRIO_MID = 2'd2;

   // level slots in the store, low to high
   localparam logic [LVL_W-1:0] SLOT_LOW  = 2'd0;
   localparam logic [LVL_W-1:0] SLOT_MID  = 2'd1;
   localparam logic [LVL_W-1:0] SLOT_HIGH = 2'd2;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // task memory access issued by the controller
   typedef struct packed {
      logic                we;
      logic                re;
      logic [ADDR_W-1:0]   addr;
      logic [ID_BITS-1:0]  wdata;
   } ram_req_type;

   // result of one item, minus the task read from memory
   typedef struct packed {
      logic                deq_ok;
      logic [LVL_W-1:0]    served_level;
      status_type          status;
      logic                all_empty;
      logic [TOTAL_W-1:0]  total;
   } res_type;

   // circular index advance
   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   // flat store address of one level entry
   function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] lv,
                                                 input logic [IDX_W-1:0] i);
      return ADDR_W'(lv) * ADDR_W'(DEPTH) + ADDR_W'(i);
   endfunction

endpackage

/* rtl/tpq_ram.sv */
`timescale 1ns / 1ps

module tpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 24
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single write port, registered read that holds between reads
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/tpq_ctrl.sv */
`timescale 1ns / 1ps

module tpq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          acc,
   input  logic                          func,
   input  logic [tpq_pkg::ID_BITS-1:0]   task_id,
   input  logic [tpq_pkg::PRIO_W-1:0]    prio,
   output tpq_pkg::ram_req_type          ram_req,
   output tpq_pkg::res_type              res
);

   logic [tpq_pkg::IDX_W-1:0] head_ff  [tpq_pkg::LEVELS];
   logic [tpq_pkg::IDX_W-1:0] head_in  [tpq_pkg::LEVELS];
   logic [tpq_pkg::IDX_W-1:0] tail_ff  [tpq_pkg::LEVELS];
   logic [tpq_pkg::IDX_W-1:0] tail_in  [tpq_pkg::LEVELS];
   logic [tpq_pkg::CNT_W-1:0] count_ff [tpq_pkg::LEVELS];
   logic [tpq_pkg::CNT_W-1:0] count_in [tpq_pkg::LEVELS];

   logic [tpq_pkg::LVL_W-1:0] enq_lv;
   logic [tpq_pkg::LVL_W-1:0] deq_lv;
   logic                      deq_any;
   logic [tpq_pkg::SUM_W-1:0] sum;

   // level chosen by the priority code
   always_comb begin
      case (prio)
         tpq_pkg::PRIO_LOW: enq_lv = tpq_pkg::SLOT_LOW;
         tpq_pkg::PRIO_MID: enq_lv = tpq_pkg::SLOT_MID;
         default:           enq_lv = tpq_pkg::SLOT_HIGH;
      endcase
   end

   // highest non-empty level
   always_comb begin
      deq_any = 1'b1;
      if (count_ff[tpq_pkg::SLOT_HIGH] != '0) begin
         deq_lv = tpq_pkg::SLOT_HIGH;
      end else if (count_ff[tpq_pkg::SLOT_MID] != '0) begin
         deq_lv = tpq_pkg::SLOT_MID;
      end else if (count_ff[tpq_pkg::SLOT_LOW] != '0) begin
         deq_lv = tpq_pkg::SLOT_LOW;
      end else begin
         deq_lv  = tpq_pkg::SLOT_LOW;
         deq_any = 1'b0;
      end
   end

   // pointer update, memory access and occupancy for an accepted item
   always_comb begin
      head_in           = head_ff;
      tail_in           = tail_ff;
      count_in          = count_ff;
      ram_req.we        = 1'b0;
      ram_req.re        = 1'b0;
      ram_req.addr      = tpq_pkg::addr_of(enq_lv, tail_ff[enq_lv]);
      ram_req.wdata     = task_id;
      res.deq_ok        = 1'b0;
      res.served_level  = '0;
      res.status        = tpq_pkg::ST_OK;
      if (acc) begin
         if (func == tpq_pkg::FUNC_ENQ) begin
            if (count_ff[enq_lv] == tpq_pkg::CNT_W'(tpq_pkg::DEPTH)) begin
               res.status = tpq_pkg::ST_FULL;
            end else begin
               ram_req.we       = 1'b1;
               tail_in[enq_lv]  = tpq_pkg::next_idx(tail_ff[enq_lv]);
               count_in[enq_lv] = count_ff[enq_lv] + 1'b1;
            end
         end else begin
            ram_req.addr = tpq_pkg::addr_of(deq_lv, head_ff[deq_lv]);
            if (!deq_any) begin
               res.status = tpq_pkg::ST_EMPTY;
            end else begin
               ram_req.re       = 1'b1;
               res.deq_ok       = 1'b1;
               res.served_level = deq_lv + 1'b1;
               head_in[deq_lv]  = tpq_pkg::next_idx(head_ff[deq_lv]);
               count_in[deq_lv] = count_ff[deq_lv] - 1'b1;
            end
         end
      end
      // occupancy after this step
      sum = tpq_pkg::SUM_W'(count_in[0]) + tpq_pkg::SUM_W'(count_in[1])
          + tpq_pkg::SUM_W'(count_in[2]);
      res.all_empty = (sum == '0);
      res.total     = tpq_pkg::TOTAL_W'(sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tpq_pkg::LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // no level ever holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff[0] <= tpq_pkg::CNT_W'(tpq_pkg::DEPTH) &&
      count_ff[1] <= tpq_pkg::CNT_W'(tpq_pkg::DEPTH) &&
      count_ff[2] <= tpq_pkg::CNT_W'(tpq_pkg::DEPTH))
      else $error("level count above depth");

   // rejected requests leave occupancy untouched
   assert property (@(posedge clock) disable iff (reset)
      (acc && res.status != tpq_pkg::ST_OK) |=>
         $stable(count_ff[0]) && $stable(count_ff[1]) && $stable(count_ff[2]))
      else $error("rejected request changed occupancy");

   // without a transfer the pointers hold
   assert property (@(posedge clock) disable iff (reset)
      !acc |=> $stable(head_ff[0]) && $stable(head_ff[1]) && $stable(head_ff[2]) &&
               $stable(tail_ff[0]) && $stable(tail_ff[1]) && $stable(tail_ff[2]))
      else $error("pointer moved without a transfer");

endmodule

/* rtl/three_level_priority_task_queue.sv */
`timescale 1ns / 1ps

// Three-level strict-priority task queue. Enqueue (req_func 0) stores req_task_id
// at the tail of level 1 or 2 when req_priority_req says so, otherwise level 3;
// dequeue (req_func 1) returns the oldest task of the highest non-empty level,
// level 3 first. A request to a full level or a dequeue with nothing stored is
// answered with a reject status and changes nothing. Every request gives exactly
// one response, in order. The three FIFOs share one task memory of 3*DEPTH
// entries with a registered read; one request is in flight at a time, and a
// request passes the memory access, then the response register, before its
// response; a new request is taken while a finished response still waits on
// rsp_stall. Stores and later reads never touch the memory in the same cycle,
// so no forwarding path is needed. No clearing pass after reset.

module three_level_priority_task_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [tpq_pkg::TASK_W-1:0]    req_task_id,
   input  logic [tpq_pkg::PRIO_W-1:0]    req_priority_req,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tpq_pkg::TASK_W-1:0]    rsp_out_task_id,
   output logic [tpq_pkg::LVL_W-1:0]     rsp_served_level,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_all_empty,
   output logic [tpq_pkg::TOTAL_W-1:0]   rsp_total_count
);

   logic                          acc;
   logic                          out_free;
   logic                          move;
   tpq_pkg::ram_req_type          ram_req;
   tpq_pkg::res_type              res;
   logic [tpq_pkg::ID_BITS-1:0]   rdata;

   logic                          pend_ff;
   logic                          pend_in;
   tpq_pkg::res_type              pres_ff;
   tpq_pkg::res_type              pres_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [tpq_pkg::TASK_W-1:0]    task_ff;
   logic [tpq_pkg::TASK_W-1:0]    task_in;
   tpq_pkg::res_type              ores_ff;
   tpq_pkg::res_type              ores_in;

   // handshake
   assign acc       = req_valid && !pend_ff;
   assign req_stall = pend_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign move      = pend_ff && out_free;

   tpq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .acc     (acc),
      .func    (req_func),
      .task_id (tpq_pkg::ID_BITS'(req_task_id)),
      .prio    (req_priority_req),
      .ram_req (ram_req),
      .res     (res)
   );

   tpq_ram #(
      .WIDTH (tpq_pkg::ID_BITS),
      .DEPTH (tpq_pkg::LEVELS * tpq_pkg::DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.addr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.addr),
      .rdata (rdata)
   );

   // pending stage waits for the memory read, then moves to the output register
   always_comb begin
      pend_in      = pend_ff;
      pres_in      = pres_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      task_in      = task_ff;
      ores_in      = ores_ff;
      if (acc) begin
         pend_in = 1'b1;
         pres_in = res;
      end else if (move) begin
         pend_in = 1'b0;
      end
      if (move) begin
         rsp_valid_in = 1'b1;
         ores_in      = pres_ff;
         task_in      = pres_ff.deq_ok ? tpq_pkg::TASK_W'(rdata) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pres_ff <= pres_in;
      task_ff <= task_in;
      ores_ff <= ores_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_task_id  = task_ff;
   assign rsp_served_level = ores_ff.served_level;
   assign rsp_status       = ores_ff.status;
   assign rsp_all_empty    = ores_ff.all_empty;
   assign rsp_total_count  = ores_ff.total;

   // a transfer always leaves one item in flight
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> pend_ff)
      else $error("accepted request not pending");

   // a pending item reaches an empty output register next cycle
   assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !rsp_valid_ff) |=> rsp_valid_ff && !pend_ff)
      else $error("pending item not delivered");

   // rejected responses carry no task and no level
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status != tpq_pkg::ST_OK) |->
         (rsp_out_task_id == '0 && rsp_served_level == '0))
      else $error("rejected response carries a task");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int RANDOM_ITEMS    = 1130;
   localparam int MAX_GAP         = 17;
   localparam int PRESSURE_AT     = 300;
   localparam int PRESSURE_CYCLES = 250;
   localparam int DRAIN_CYCLES    = 20;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int PRINT_CAP       = 40;

   // shape of one stretch of random traffic
   typedef enum int {
      PH_FILL,
      PH_DRAIN,
      PH_MIXED
   } phase_kind_type;

   typedef struct packed {
      logic [tpq_pkg::TASK_W-1:0]  task_id;
      logic [tpq_pkg::LVL_W-1:0]   level;
      tpq_pkg::status_type         status;
      logic                        empty;
      logic [tpq_pkg::TOTAL_W-1:0] total;
   } queue_result_type;

   typedef struct {
      logic                        func;
      logic [tpq_pkg::TASK_W-1:0]  id;
      logic [tpq_pkg::PRIO_W-1:0]  prio;
      bit                          typed;
      queue_result_type            res;
   } stim_row_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_func;
   logic [tpq_pkg::TASK_W-1:0]   req_task_id;
   logic [tpq_pkg::PRIO_W-1:0]   req_priority_req;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [tpq_pkg::TASK_W-1:0]   rsp_out_task_id;
   logic [tpq_pkg::LVL_W-1:0]    rsp_served_level;
   logic [1:0]                   rsp_status;
   logic                         rsp_all_empty;
   logic [tpq_pkg::TOTAL_W-1:0]  rsp_total_count;

   // shadow copy of the three level fifos
   logic [tpq_pkg::ID_BITS-1:0]  level_mem [tpq_pkg::LEVELS][tpq_pkg::DEPTH];
   int                           level_head [tpq_pkg::LEVELS];
   int                           level_tail [tpq_pkg::LEVELS];
   int                           level_fill [tpq_pkg::LEVELS];

   queue_result_type    pending_results [$];
   stim_row_type        stim_rows [$];

   bit                  row_typed;
   queue_result_type    row_result;

   int                  error_count;
   int                  items_taken;
   int                  rsp_count;
   int                  full_rejects;
   int                  empty_rejects;
   int                  peak_total;
   int                  cycle_count;
   bit                  pressure_done;

   three_level_priority_task_queue DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_task_id  (rsp_out_task_id),
      .rsp_served_level (rsp_served_level),
      .rsp_status       (rsp_status),
      .rsp_all_empty    (rsp_all_empty),
      .rsp_total_count  (rsp_total_count)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   initial begin
      reset = 1'b1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
   end

   // run limit
   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  cycle_count, pending_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (error_count < PRINT_CAP) begin
         $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                  rsp_count, what, got, want);
      end
      error_count++;
   endtask

   // strict-priority queue predictor, one call per accepted request
   function automatic queue_result_type predict_queue(
         input logic func,
         input logic [tpq_pkg::TASK_W-1:0] id,
         input logic [tpq_pkg::PRIO_W-1:0] prio);
      queue_result_type r;
      int               slot;
      int               sum;
      r = '0;
      r.status = tpq_pkg::ST_OK;
      if (func == tpq_pkg::FUNC_ENQ) begin
         if (prio == tpq_pkg::PRIO_LOW) begin
            slot = tpq_pkg::SLOT_LOW;
         end else if (prio == tpq_pkg::PRIO_MID) begin
            slot = tpq_pkg::SLOT_MID;
         end else begin
            slot = tpq_pkg::SLOT_HIGH;
         end
         if (level_fill[slot] >= tpq_pkg::DEPTH) begin
            r.status = tpq_pkg::ST_FULL;
         end else begin
            level_mem[slot][level_tail[slot]] = id[tpq_pkg::ID_BITS-1:0];
            level_tail[slot] = (level_tail[slot] == tpq_pkg::DEPTH - 1) ?
                               0 : level_tail[slot] + 1;
            level_fill[slot]++;
         end
      end else begin
         slot = -1;
         if (level_fill[tpq_pkg::SLOT_HIGH] != 0) begin
            slot = tpq_pkg::SLOT_HIGH;
         end else if (level_fill[tpq_pkg::SLOT_MID] != 0) begin
            slot = tpq_pkg::SLOT_MID;
         end else if (level_fill[tpq_pkg::SLOT_LOW] != 0) begin
            slot = tpq_pkg::SLOT_LOW;
         end
         if (slot < 0) begin
            r.status = tpq_pkg::ST_EMPTY;
         end else begin
            r.task_id = tpq_pkg::TASK_W'(level_mem[slot][level_head[slot]]);
            level_head[slot] = (level_head[slot] == tpq_pkg::DEPTH - 1) ?
                               0 : level_head[slot] + 1;
            level_fill[slot]--;
            r.level = tpq_pkg::LVL_W'(slot + 1);
         end
      end
      sum = level_fill[0] + level_fill[1] + level_fill[2];
      r.empty = (sum == 0);
      r.total = tpq_pkg::TOTAL_W'(sum);
      return r;
   endfunction

   function automatic void add_row(input logic func,
                                   input logic [tpq_pkg::TASK_W-1:0] id,
                                   input logic [tpq_pkg::PRIO_W-1:0] prio,
                                   input bit typed,
                                   input logic [tpq_pkg::TASK_W-1:0] want_id,
                                   input logic [tpq_pkg::LVL_W-1:0] want_lvl,
                                   input tpq_pkg::status_type want_st,
                                   input logic want_empty,
                                   input int want_total);
      stim_row_type row;
      row.func = func;
      row.id = id;
      row.prio = prio;
      row.typed = typed;
      row.res.task_id = want_id;
      row.res.level = want_lvl;
      row.res.status = want_st;
      row.res.empty = want_empty;
      row.res.total = tpq_pkg::TOTAL_W'(want_total);
      stim_rows.push_back(row);
   endfunction

   // request and result transfers: predict on the one, check on the other
   always @(posedge clock) begin : monitor
      queue_result_type calc;
      queue_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            calc = predict_queue(req_func, req_task_id, req_priority_req);
            pending_results.push_back(row_typed ? row_result : calc);
            items_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (pending_results.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_status, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_out_task_id !== want.task_id)
                  report_mismatch("out_task_id", rsp_out_task_id, want.task_id);
               if (rsp_served_level !== want.level)
                  report_mismatch("served_level", rsp_served_level, want.level);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_all_empty !== want.empty)
                  report_mismatch("all_empty", rsp_all_empty, want.empty);
               if (rsp_total_count !== want.total)
                  report_mismatch("total_count", rsp_total_count, want.total);
               if (want.status == tpq_pkg::ST_FULL) full_rejects++;
               if (want.status == tpq_pkg::ST_EMPTY) empty_rejects++;
               if (int'(want.total) > peak_total) peak_total = want.total;
            end
         end
      end
   end

   // offer one request after a gap and hold it until the transfer
   task automatic drive_request(input logic func,
                                input logic [tpq_pkg::TASK_W-1:0] id,
                                input logic [tpq_pkg::PRIO_W-1:0] prio,
                                input int gap,
                                input bit typed, input queue_result_type res);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      row_typed = typed;
      row_result = res;
      req_valid <= 1'b1;
      req_func <= func;
      req_task_id <= id;
      req_priority_req <= prio;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver: random stall per result, plus one long hold-off
   initial begin
      int hold;
      int k;
      bit quiet_rx;
      rsp_stall = 1'b0;
      quiet_rx = 1'b0;
      k = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (k % 40 == 0) quiet_rx = ($urandom_range(0, 2) == 0);
         k++;
         hold = quiet_rx ? 0 : $urandom_range(0, MAX_GAP);
         if (!pressure_done && rsp_count >= PRESSURE_AT) begin
            hold = PRESSURE_CYCLES;
            pressure_done = 1'b1;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // sender: directed rows, then phased random traffic, then the end check
   initial begin
      stim_row_type                 row;
      phase_kind_type               phase_mode;
      int                           phase_left;
      bit                           fixed_prio;
      logic [tpq_pkg::PRIO_W-1:0]   phase_prio;
      bit                           quiet_tx;
      int                           deq_pct;
      logic                         func;
      logic [tpq_pkg::PRIO_W-1:0]   prio;
      queue_result_type             none;

      req_valid = 1'b0;
      req_func = tpq_pkg::FUNC_ENQ;
      req_task_id = '0;
      req_priority_req = '0;
      row_typed = 1'b0;
      row_result = '0;
      none = '0;
      error_count = 0;
      items_taken = 0;
      rsp_count = 0;
      full_rejects = 0;
      empty_rejects = 0;
      peak_total = 0;
      pressure_done = 1'b0;
      for (int l = 0; l < tpq_pkg::LEVELS; l++) begin
         level_head[l] = 0;
         level_tail[l] = 0;
         level_fill[l] = 0;
         for (int d = 0; d < tpq_pkg::DEPTH; d++) level_mem[l][d] = '0;
      end

      // empty after reset, two high tasks and one each for middle and low, priority order on the way out
      add_row(tpq_pkg::FUNC_DEQ, 16'h0000, 2'd0, 1, 16'h0000, 2'd0,
              tpq_pkg::ST_EMPTY, 1'b1, 0);
      add_row(tpq_pkg::FUNC_ENQ, 16'hFFFF, 2'd3, 1, 16'h0000, 2'd0,
              tpq_pkg::ST_OK, 1'b0, 1);
      add_row(tpq_pkg::FUNC_ENQ, 16'h0000, 2'd0, 1, 16'h0000, 2'd0,
              tpq_pkg::ST_OK, 1'b0, 2);
      add_row(tpq_pkg::FUNC_ENQ, 16'h1234, tpq_pkg::PRIO_LOW, 1, 16'h0000, 2'd0,
              tpq_pkg::ST_OK, 1'b0, 3);
      add_row(tpq_pkg::FUNC_ENQ, 16'hABCD, tpq_pkg::PRIO_MID, 1, 16'h0000, 2'd0,
              tpq_pkg::ST_OK, 1'b0, 4);
      add_row(tpq_pkg::FUNC_DEQ, 16'h5555, tpq_pkg::PRIO_LOW, 1, 16'hFFFF, 2'd3,
              tpq_pkg::ST_OK, 1'b0, 3);
      add_row(tpq_pkg::FUNC_DEQ, 16'hFFFF, 2'd3, 1, 16'h0000, 2'd3,
              tpq_pkg::ST_OK, 1'b0, 2);
      add_row(tpq_pkg::FUNC_DEQ, 16'h0000, 2'd0, 1, 16'hABCD, 2'd2,
              tpq_pkg::ST_OK, 1'b0, 1);
      add_row(tpq_pkg::FUNC_DEQ, 16'h0000, 2'd0, 1, 16'h1234, 2'd1,
              tpq_pkg::ST_OK, 1'b1, 0);
      add_row(tpq_pkg::FUNC_DEQ, 16'hAAAA, 2'd2, 1, 16'h0000, 2'd0,
              tpq_pkg::ST_EMPTY, 1'b1, 0);
      // fill the low level, then one more is rejected as full
      for (int i = 0; i < tpq_pkg::DEPTH; i++)
         add_row(tpq_pkg::FUNC_ENQ, tpq_pkg::TASK_W'(16'h8000 + i), tpq_pkg::PRIO_LOW,
                 0, '0, '0, tpq_pkg::ST_OK, 1'b0, 0);
      add_row(tpq_pkg::FUNC_ENQ, 16'h4321, tpq_pkg::PRIO_LOW, 1, 16'h0000, 2'd0,
              tpq_pkg::ST_FULL, 1'b0, tpq_pkg::DEPTH);
      // middle task overtakes the full low level
      add_row(tpq_pkg::FUNC_ENQ, 16'h7FFF, tpq_pkg::PRIO_MID, 0, '0, '0,
              tpq_pkg::ST_OK, 1'b0, 0);
      add_row(tpq_pkg::FUNC_DEQ, 16'h0000, 2'd0, 0, '0, '0, tpq_pkg::ST_OK, 1'b0, 0);
      add_row(tpq_pkg::FUNC_DEQ, 16'h0000, 2'd0, 0, '0, '0, tpq_pkg::ST_OK, 1'b0, 0);

      wait (!reset);
      @(negedge clock);

      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         drive_request(row.func, row.id, row.prio, $urandom_range(0, MAX_GAP),
                       row.typed, row.res);
      end

      phase_left = 0;
      phase_mode = PH_MIXED;
      fixed_prio = 1'b0;
      phase_prio = '0;
      quiet_tx = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // new stretch: fill, drain or mixed, maybe one level only
         if (phase_left == 0) begin
            phase_mode = phase_kind_type'($urandom_range(0, 2));
            phase_left = $urandom_range(10, 60);
            fixed_prio = ($urandom_range(0, 1) == 0);
            phase_prio = tpq_pkg::PRIO_W'($urandom_range(0, 3));
            quiet_tx = ($urandom_range(0, 3) == 0);
         end
         phase_left--;
         case (phase_mode)
            PH_FILL: begin
               deq_pct = 15;
            end
            PH_DRAIN: begin
               deq_pct = 85;
            end
            default: begin
               deq_pct = 50;
            end
         endcase
         func = ($urandom_range(0, 99) < deq_pct) ? tpq_pkg::FUNC_DEQ : tpq_pkg::FUNC_ENQ;
         prio = fixed_prio ? phase_prio : tpq_pkg::PRIO_W'($urandom_range(0, 3));
         drive_request(func, tpq_pkg::TASK_W'($urandom()), prio,
                       quiet_tx ? 0 : $urandom_range(0, MAX_GAP), 1'b0, none);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests, %0d results; %0d full rejects, %0d empty rejects",
               items_taken, rsp_count, full_rejects, empty_rejects);
      $display("peak occupancy %0d tasks, long receiver hold-off %0s",
               peak_total, pressure_done ? "done" : "not reached");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
